/* hw/rtl/spfd_pkg.sv */
// Shared types, codes and defaults for the serial port with receive FIFO and DMA.
`default_nettype none

package spfd_pkg;

  localparam int          FIFO_DEPTH_DEF = 16;
  localparam logic [31:0] DEVICE_ID_DEF  = 32'h0000_0000;
  localparam int          QUEUE_DEPTH    = 2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Request types
  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_RX_BYTE = 2'd2;

  // Word indexes of the register map
  localparam int         WORD_W         = 10;
  localparam logic [9:0] REG_ID         = 10'd0;
  localparam logic [9:0] REG_DATA       = 10'd1;
  localparam logic [9:0] REG_FIFO_COUNT = 10'd2;
  localparam logic [9:0] REG_INT_ENABLE = 10'd3;
  localparam logic [9:0] REG_TX_ADDR    = 10'd4;
  localparam logic [9:0] REG_TX_COUNT   = 10'd5;
  localparam logic [9:0] REG_RX_ADDR    = 10'd6;
  localparam logic [9:0] REG_RX_COUNT   = 10'd7;
  localparam logic [9:0] REG_FIFO_SIZE  = 10'd8;

  // Memory side operations
  localparam logic [1:0] MEM_NONE    = 2'd0;
  localparam logic [1:0] MEM_BYTE_WR = 2'd1;
  localparam logic [1:0] MEM_TX_DMA  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_OFFSET = 2'd1;
  localparam logic [1:0] ERR_RX_DROP    = 2'd2;

  // Interrupt enable bits
  localparam int IRQ_FIFO_BIT     = 0;
  localparam int IRQ_ALWAYS_BIT   = 1;
  localparam int IRQ_DMA_DONE_BIT = 2;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_BAD,
    CMD_RD_ID,
    CMD_RD_DATA,
    CMD_RD_COUNT,
    CMD_RD_MASK,
    CMD_RD_TXADDR,
    CMD_RD_ZERO,
    CMD_RD_RXADDR,
    CMD_RD_RXLEFT,
    CMD_RD_SIZE,
    CMD_WR_DATA,
    CMD_WR_MASK,
    CMD_WR_TXADDR,
    CMD_WR_TXCNT,
    CMD_WR_RXADDR,
    CMD_WR_RXCNT,
    CMD_RX_BYTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;
    logic [7:0]  rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [7:0]  mem_byte;
    logic [31:0] tx_dma_count;
    logic [31:0] rx_space;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/spfd_queue.sv */
// Small register queue used between the front, the back and the result port.
`default_nettype none

module spfd_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = spfd_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire T     wr_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          rd_data_o,
  output logic      empty_o
);
  import spfd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  T              entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full_o    = (count_r == DEPTH_C);
  assign empty_o   = (count_r == '0);
  assign rd_data_o = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && full_o |-> pop_i)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

/* hw/rtl/spfd_front.sv */
// Front end: accepts bus and line items and classifies them into commands.
`default_nettype none

module spfd_front (
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] reg_offset_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  rx_data_i,
  input  wire logic        cmdq_full_i,
  output logic             cmd_push_o,
  output spfd_pkg::cmd_t   cmd_o
);
  import spfd_pkg::*;

  logic [WORD_W-1:0] word;

  assign word       = reg_offset_i[11:2];
  assign full       = cmdq_full_i;
  assign cmd_push_o = push && !cmdq_full_i;

  always_comb begin
    cmd_o.data    = write_data_i;
    cmd_o.rx_byte = rx_data_i;
    cmd_o.kind    = CMD_NOP;
    case (req_type_i)
      REQ_READ: begin
        case (word)
          REG_ID:         cmd_o.kind = CMD_RD_ID;
          REG_DATA:       cmd_o.kind = CMD_RD_DATA;
          REG_FIFO_COUNT: cmd_o.kind = CMD_RD_COUNT;
          REG_INT_ENABLE: cmd_o.kind = CMD_RD_MASK;
          REG_TX_ADDR:    cmd_o.kind = CMD_RD_TXADDR;
          REG_TX_COUNT:   cmd_o.kind = CMD_RD_ZERO;
          REG_RX_ADDR:    cmd_o.kind = CMD_RD_RXADDR;
          REG_RX_COUNT:   cmd_o.kind = CMD_RD_RXLEFT;
          REG_FIFO_SIZE:  cmd_o.kind = CMD_RD_SIZE;
          default:        cmd_o.kind = CMD_BAD;
        endcase
      end
      REQ_WRITE: begin
        case (word)
          REG_DATA:       cmd_o.kind = CMD_WR_DATA;
          REG_INT_ENABLE: cmd_o.kind = CMD_WR_MASK;
          REG_TX_ADDR:    cmd_o.kind = CMD_WR_TXADDR;
          REG_TX_COUNT:   cmd_o.kind = CMD_WR_TXCNT;
          REG_RX_ADDR:    cmd_o.kind = CMD_WR_RXADDR;
          REG_RX_COUNT:   cmd_o.kind = CMD_WR_RXCNT;
          default:        cmd_o.kind = CMD_BAD;
        endcase
      end
      REQ_RX_BYTE: cmd_o.kind = CMD_RX_BYTE;
      default:     cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/spfd_back.sv */
// Back end: register state, receive ring FIFO and DMA sequencing, one command at a time.
`default_nettype none

module spfd_back #(
  parameter int          FIFO_DEPTH = spfd_pkg::FIFO_DEPTH_DEF,
  parameter logic [31:0] DEVICE_ID  = spfd_pkg::DEVICE_ID_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spfd_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output spfd_pkg::res_t      res_o,
  output logic                res_push_o,
  input  wire logic           res_full_i
);
  import spfd_pkg::*;

  localparam int IW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
  localparam logic [CW:0]   DEPTH_W  = (CW+1)'(FIFO_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DRD, S_DEMIT} state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [31:0]   mask_r, mask_nxt;
  logic [31:0]   tx_addr_r, tx_addr_nxt;
  logic [31:0]   rx_addr_r, rx_addr_nxt;
  logic [31:0]   rx_left_r, rx_left_nxt;

  // Ring storage, written at the tail, read at the head
  logic [7:0]    store_r [FIFO_DEPTH];
  logic [7:0]    rd_byte_r;
  logic          wr_en;
  logic [IW-1:0] wr_idx;

  logic [IW-1:0] head_inc;
  logic [CW:0]   tail_sum;
  logic [IW-1:0] tail_idx;
  logic [31:0]   left_v;
  logic [CW-1:0] len_v;

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(fill_r);
  assign tail_idx = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : IW'(tail_sum);

  // Receive DMA start: drain what is buffered, leave the rest for the line
  always_comb begin
    if (32'(fill_r) < cmd_r.data) begin
      left_v = cmd_r.data - 32'(fill_r);
      len_v  = fill_r;
    end else begin
      left_v = '0;
      len_v  = cmd_r.data[CW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    mask_nxt    = mask_r;
    tx_addr_nxt = tx_addr_r;
    rx_addr_nxt = rx_addr_r;
    rx_left_nxt = rx_left_r;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = tail_idx;
    res_o       = '0;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_nxt   = cmd_i;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.kind == CMD_WR_RXCNT && len_v != '0) begin
          rx_left_nxt = left_v;
          len_nxt     = len_v;
          state_nxt   = S_DEMIT;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          state_nxt  = S_IDLE;
          case (cmd_r.kind)
            CMD_BAD:       res_o.error_code = ERR_BAD_OFFSET;
            CMD_RD_ID:     res_o.read_data  = DEVICE_ID;
            CMD_RD_DATA: begin
              if (fill_r != '0) begin
                res_o.read_data = {24'h0, rd_byte_r};
                head_nxt        = head_inc;
                fill_nxt        = fill_r - 1'b1;
              end else begin
                res_o.read_data = ALL_ONES;
              end
            end
            CMD_RD_COUNT:  res_o.read_data = 32'(fill_r);
            CMD_RD_MASK:   res_o.read_data = mask_r;
            CMD_RD_TXADDR: res_o.read_data = tx_addr_r;
            CMD_RD_RXADDR: res_o.read_data = rx_addr_r;
            CMD_RD_RXLEFT: res_o.read_data = rx_left_r;
            CMD_RD_SIZE:   res_o.read_data = 32'(FIFO_DEPTH);
            CMD_WR_DATA: begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = cmd_r.data[7:0];
            end
            CMD_WR_MASK:   mask_nxt    = cmd_r.data;
            CMD_WR_TXADDR: tx_addr_nxt = cmd_r.data;
            CMD_WR_TXCNT: begin
              if (cmd_r.data != '0) begin
                res_o.mem_op       = MEM_TX_DMA;
                res_o.mem_addr     = tx_addr_r;
                res_o.tx_dma_count = cmd_r.data;
                tx_addr_nxt        = tx_addr_r + cmd_r.data;
              end
            end
            CMD_WR_RXADDR: begin
              rx_left_nxt = '0;
              rx_addr_nxt = cmd_r.data;
            end
            CMD_WR_RXCNT:  rx_left_nxt = left_v;
            CMD_RX_BYTE: begin
              if (rx_left_r != '0) begin
                res_o.mem_op   = MEM_BYTE_WR;
                res_o.mem_addr = rx_addr_r;
                res_o.mem_byte = cmd_r.rx_byte;
                rx_left_nxt    = rx_left_r - 1'b1;
                rx_addr_nxt    = rx_addr_r + 1'b1;
              end else if (fill_r < DEPTH_C) begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end else begin
                res_o.error_code = ERR_RX_DROP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRD: begin
        // head moved: let the read port catch up
        state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        if (!res_full_i) begin
          res_push_o     = 1'b1;
          res_o.mem_op   = MEM_BYTE_WR;
          res_o.mem_addr = rx_addr_r;
          res_o.mem_byte = rd_byte_r;
          res_o.last     = (len_r == CW'(1));
          rx_addr_nxt    = rx_addr_r + 1'b1;
          head_nxt       = head_inc;
          fill_nxt       = fill_r - 1'b1;
          len_nxt        = len_r - 1'b1;
          state_nxt      = (len_r == CW'(1)) ? S_IDLE : S_DRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // irq and space reflect state after this result
    res_o.irq_level = (mask_nxt[IRQ_FIFO_BIT] && fill_nxt != '0) ||
                      mask_nxt[IRQ_ALWAYS_BIT] ||
                      (mask_nxt[IRQ_DMA_DONE_BIT] && rx_left_nxt == '0);
    res_o.rx_space  = (rx_left_nxt != '0) ? rx_left_nxt : 32'(DEPTH_C - fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      fill_r    <= '0;
      len_r     <= '0;
      mask_r    <= '0;
      tx_addr_r <= '0;
      rx_addr_r <= '0;
      rx_left_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      len_r     <= len_nxt;
      mask_r    <= mask_nxt;
      tx_addr_r <= tx_addr_nxt;
      rx_addr_r <= rx_addr_nxt;
      rx_left_r <= rx_left_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= cmd_r.rx_byte;
    end
    rd_byte_r <= store_r[head_r];
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count above depth");
  a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEMIT || state_r == S_DRD) |-> (len_r != '0 && len_r <= fill_r))
    else $error("drain length out of step with fill count");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/serial_port_rx_fifo_dma.sv */
// Top level of the serial port with receive FIFO and DMA.
//
// Usage:
//   Input channel (push/full): each item is a bus read, a bus write or one
//   received serial byte. An item is taken on a clock edge with push high
//   and full low. A two-entry command queue sits in front of the engine.
//   Result channel (empty/pop): results wait in a two-entry queue; the
//   oldest one is on the out_ ports while empty is low and leaves on an edge
//   with pop high. Every item yields one result, except a receive DMA start
//   with bytes buffered, which yields one memory byte write per drained
//   byte (up to FIFO_DEPTH); out_last marks the final result of an item.
//   The engine takes one item at a time: it fetches the item from the
//   command queue, then executes it and pushes its result; a receive DMA
//   drain holds it until the last byte write is out, with a wait state
//   between writes for the registered ring read port.
//   Reset (rst_n low, synchronous) empties both queues and the receive FIFO
//   and clears the control registers; FIFO storage itself is not cleared.
//   A stalled receiver fills the result queue; the engine then waits, the
//   command queue fills and full rises. No item is dropped by the stall.
`default_nettype none

module serial_port_rx_fifo_dma #(
  parameter int          FIFO_DEPTH = spfd_pkg::FIFO_DEPTH_DEF,
  parameter logic [31:0] DEVICE_ID  = spfd_pkg::DEVICE_ID_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [11:0] in_reg_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [7:0]  in_rx_data,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_read_data,
  output logic             out_irq_level,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic [1:0]       out_mem_op,
  output logic [31:0]      out_mem_addr,
  output logic [7:0]       out_mem_byte,
  output logic [31:0]      out_tx_dma_count,
  output logic [31:0]      out_rx_space,
  output logic [1:0]       out_error_code,
  output logic             out_last
);
  import spfd_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  res_t res_in, res_head;
  logic res_push, res_full;

  // Front: decode the item into a command
  spfd_front u_front (
    .push         (push),
    .full         (full),
    .req_type_i   (in_req_type),
    .reg_offset_i (in_reg_offset),
    .write_data_i (in_write_data),
    .rx_data_i    (in_rx_data),
    .cmdq_full_i  (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // Command queue decouples the bus side from the engine
  spfd_queue #(.T(cmd_t), .DEPTH(QUEUE_DEPTH)) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (cmd_push),
    .wr_data_i (cmd_in),
    .full_o    (cmd_full),
    .pop_i     (cmd_pop),
    .rd_data_o (cmd_head),
    .empty_o   (cmd_empty)
  );

  // Back: registers, ring FIFO, DMA sequencing
  spfd_back #(.FIFO_DEPTH(FIFO_DEPTH), .DEVICE_ID(DEVICE_ID)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue: engine keeps going while the receiver holds a result, until the queue is full
  spfd_queue #(.T(res_t), .DEPTH(QUEUE_DEPTH)) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .pop_i     (pop && !empty),
    .rd_data_o (res_head),
    .empty_o   (empty)
  );

  assign out_read_data    = res_head.read_data;
  assign out_irq_level    = res_head.irq_level;
  assign out_tx_valid     = res_head.tx_valid;
  assign out_tx_byte      = res_head.tx_byte;
  assign out_mem_op       = res_head.mem_op;
  assign out_mem_addr     = res_head.mem_addr;
  assign out_mem_byte     = res_head.mem_byte;
  assign out_tx_dma_count = res_head.tx_dma_count;
  assign out_rx_space     = res_head.rx_space;
  assign out_error_code   = res_head.error_code;
  assign out_last         = res_head.last;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the serial port with receive FIFO and DMA.
`timescale 1ns / 100ps

module tb_top;
  import spfd_pkg::*;

  // Request type that the block must treat as a no-op
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 80;
  localparam int         CALM_ITEMS   = 30;    // final stretch without idling
  localparam int         HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int         DRAIN_LIMIT  = 20000;
  localparam int         SETTLE       = 20;

  // Tracks the port state, predicts results per item and checks them in order.
  class rx_dma_scoreboard;
    res_t        expected_q[$];
    int unsigned errors;
    int unsigned results_seen;
    logic [7:0]  ring[FIFO_DEPTH_DEF];
    int          head_idx;
    int          fill_cnt;
    logic [31:0] mask;
    logic [31:0] tx_ptr;
    logic [31:0] rx_ptr;
    logic [31:0] rx_left;

    function new();
      errors = 0;
      results_seen = 0;
      head_idx = 0;
      fill_cnt = 0;
      mask = '0;
      tx_ptr = '0;
      rx_ptr = '0;
      rx_left = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] take_byte();
      logic [7:0] b;
      b = ring[head_idx];
      fill_cnt--;
      head_idx = (head_idx + 1) % FIFO_DEPTH_DEF;
      return b;
    endfunction

    // irq and rx_space reflect the state after this result
    function void add_result(logic [31:0] rd, logic txv, logic [7:0] txb, logic [1:0] op,
                             logic [31:0] addr, logic [7:0] mb, logic [31:0] cnt,
                             logic [1:0] err);
      res_t r;
      r.read_data    = rd;
      r.irq_level    = (mask[IRQ_FIFO_BIT] && fill_cnt != 0) || mask[IRQ_ALWAYS_BIT] ||
                       (mask[IRQ_DMA_DONE_BIT] && rx_left == 0);
      r.tx_valid     = txv;
      r.tx_byte      = txb;
      r.mem_op       = op;
      r.mem_addr     = addr;
      r.mem_byte     = mb;
      r.tx_dma_count = cnt;
      r.rx_space     = (rx_left != 0) ? rx_left : 32'(FIFO_DEPTH_DEF - fill_cnt);
      r.error_code   = err;
      r.last         = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void add_status(logic [1:0] err);
      add_result('0, 1'b0, '0, MEM_NONE, '0, '0, '0, err);
    endfunction

    function void note_item(logic [1:0] kind, logic [11:0] offset, logic [31:0] wdata,
                            logic [7:0] rxb);
      logic [9:0]  word;
      logic [31:0] rd;
      logic [31:0] len;
      logic [31:0] a;
      logic [7:0]  b;
      logic [1:0]  err;
      int          slot;
      word = offset[11:2];
      rd = '0;
      err = ERR_NONE;
      case (kind)
        REQ_READ: begin
          case (word)
            REG_ID:         rd = DEVICE_ID_DEF;
            REG_DATA:       rd = (fill_cnt > 0) ? {24'h0, take_byte()} : ALL_ONES;
            REG_FIFO_COUNT: rd = 32'(fill_cnt);
            REG_INT_ENABLE: rd = mask;
            REG_TX_ADDR:    rd = tx_ptr;
            REG_TX_COUNT:   rd = '0;
            REG_RX_ADDR:    rd = rx_ptr;
            REG_RX_COUNT:   rd = rx_left;
            REG_FIFO_SIZE:  rd = 32'(FIFO_DEPTH_DEF);
            default:        err = ERR_BAD_OFFSET;
          endcase
          add_result(rd, 1'b0, '0, MEM_NONE, '0, '0, '0, err);
        end
        REQ_WRITE: begin
          case (word)
            REG_DATA: add_result('0, 1'b1, wdata[7:0], MEM_NONE, '0, '0, '0, ERR_NONE);
            REG_INT_ENABLE: begin
              mask = wdata;
              add_status(ERR_NONE);
            end
            REG_TX_ADDR: begin
              tx_ptr = wdata;
              add_status(ERR_NONE);
            end
            REG_TX_COUNT: begin
              if (wdata != 0) begin
                a = tx_ptr;
                tx_ptr = a + wdata;
                add_result('0, 1'b0, '0, MEM_TX_DMA, a, '0, wdata, ERR_NONE);
              end else begin
                add_status(ERR_NONE);
              end
            end
            REG_RX_ADDR: begin
              // also cancels a pending receive DMA
              rx_left = '0;
              rx_ptr = wdata;
              add_status(ERR_NONE);
            end
            REG_RX_COUNT: begin
              len = wdata;
              if (fill_cnt < len) begin
                rx_left = len - fill_cnt;
                len = fill_cnt;
              end else begin
                rx_left = '0;
              end
              if (len == 0) add_status(ERR_NONE);
              while (len != 0) begin
                a = rx_ptr;
                b = take_byte();
                rx_ptr = a + 1;
                len--;
                add_result('0, 1'b0, '0, MEM_BYTE_WR, a, b, '0, ERR_NONE);
              end
            end
            default: add_status(ERR_BAD_OFFSET);
          endcase
        end
        REQ_RX_BYTE: begin
          if (rx_left != 0) begin
            a = rx_ptr;
            rx_left--;
            rx_ptr = a + 1;
            add_result('0, 1'b0, '0, MEM_BYTE_WR, a, rxb, '0, ERR_NONE);
          end else if (fill_cnt < FIFO_DEPTH_DEF) begin
            slot = (head_idx + fill_cnt) % FIFO_DEPTH_DEF;
            ring[slot] = rxb;
            fill_cnt++;
            add_status(ERR_NONE);
          end else begin
            add_status(ERR_RX_DROP);
          end
        end
        default: add_status(ERR_NONE);
      endcase
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR @%0t result %0d: %s got %h want %h",
               $realtime, results_seen, what, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with nothing expected", got.read_data, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data)
        report("read_data", got.read_data, want.read_data);
      if (got.irq_level !== want.irq_level)
        report("irq_level", 32'(got.irq_level), 32'(want.irq_level));
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      if (got.mem_op !== want.mem_op)
        report("mem_op", 32'(got.mem_op), 32'(want.mem_op));
      if (got.mem_addr !== want.mem_addr)
        report("mem_addr", got.mem_addr, want.mem_addr);
      if (got.mem_byte !== want.mem_byte)
        report("mem_byte", 32'(got.mem_byte), 32'(want.mem_byte));
      if (got.tx_dma_count !== want.tx_dma_count)
        report("tx_dma_count", got.tx_dma_count, want.tx_dma_count);
      if (got.rx_space !== want.rx_space)
        report("rx_space", got.rx_space, want.rx_space);
      if (got.error_code !== want.error_code)
        report("error_code", 32'(got.error_code), 32'(want.error_code));
      if (got.last !== want.last)
        report("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  in_req_type = REQ_READ;
  logic [11:0] in_reg_offset = '0;
  logic [31:0] in_write_data = '0;
  logic [7:0]  in_rx_data = '0;
  wire         full;
  wire         empty;
  wire [31:0]  out_read_data;
  wire         out_irq_level;
  wire         out_tx_valid;
  wire [7:0]   out_tx_byte;
  wire [1:0]   out_mem_op;
  wire [31:0]  out_mem_addr;
  wire [7:0]   out_mem_byte;
  wire [31:0]  out_tx_dma_count;
  wire [31:0]  out_rx_space;
  wire [1:0]   out_error_code;
  wire         out_last;

  // set for the final stretch of the run: no idling on either side
  bit calm = 1'b0;

  rx_dma_scoreboard sb = new();

  serial_port_rx_fifo_dma u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_reg_offset    (in_reg_offset),
    .in_write_data    (in_write_data),
    .in_rx_data       (in_rx_data),
    .empty            (empty),
    .pop              (pop),
    .out_read_data    (out_read_data),
    .out_irq_level    (out_irq_level),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_mem_op       (out_mem_op),
    .out_mem_addr     (out_mem_addr),
    .out_mem_byte     (out_mem_byte),
    .out_tx_dma_count (out_tx_dma_count),
    .out_rx_space     (out_rx_space),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item and wait for the edge that takes it. Unless a sender gap is taken,
  // push stays high on return so back-to-back items never drop it within one step.
  task automatic send_item(logic [1:0] kind, logic [11:0] offset, logic [31:0] wdata,
                           logic [7:0] rxb);
    int n;
    push          <= 1'b1;
    in_req_type   <= kind;
    in_reg_offset <= offset;
    in_write_data <= wdata;
    in_rx_data    <= rxb;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(kind, offset, wdata, rxb);
    // random sender gap, none in the calm stretch
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Bus accesses get random byte-lane bits in the offset; the unused fields
  // carry random values that the block must ignore.
  task automatic bus_read(logic [9:0] word);
    logic [1:0] lo;
    lo = 2'($urandom_range(0, 3));
    send_item(REQ_READ, {word, lo}, $urandom(), 8'($urandom_range(0, 255)));
  endtask

  task automatic bus_write(logic [9:0] word, logic [31:0] wdata);
    logic [1:0] lo;
    lo = 2'($urandom_range(0, 3));
    send_item(REQ_WRITE, {word, lo}, wdata, 8'($urandom_range(0, 255)));
  endtask

  task automatic rx_byte(logic [7:0] b);
    send_item(REQ_RX_BYTE, 12'($urandom_range(0, 4095)), $urandom(), b);
  endtask

  // Result side: check every accepted result, random pop gaps, and one long
  // hold-off early on so the result queue, then the command queue, fill up
  // and full rises while items keep being offered.
  initial begin : result_drain
    res_t got;
    int   hold_left;
    int   gap_left;
    bit   held;
    hold_left = 0;
    gap_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got = '{out_read_data, out_irq_level, out_tx_valid, out_tx_byte, out_mem_op,
                out_mem_addr, out_mem_byte, out_tx_dma_count, out_rx_space,
                out_error_code, out_last};
        sb.check_result(got);
      end
      if (!held && sb.results_seen >= 5) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 4) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int sel;
    int burst;
    int guard;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    send_item(REQ_READ, {REG_ID, 2'b00}, '0, '0);
    bus_read(REG_DATA);                              // empty FIFO reads all ones
    bus_read(REG_FIFO_SIZE);
    send_item(REQ_READ, 12'hFFF, ALL_ONES, 8'hFF);   // bad offset, top of range
    bus_write(REG_ID, ALL_ONES);                     // read-only registers
    bus_write(REG_FIFO_SIZE, '0);
    send_item(REQ_UNUSED, 12'hFFF, ALL_ONES, 8'hFF); // unused type does nothing
    bus_write(REG_INT_ENABLE, 32'h0000_0004);        // DMA-done interrupt
    bus_write(REG_TX_ADDR, ALL_ONES);
    bus_write(REG_TX_COUNT, ALL_ONES);                // pointer wraps
    bus_write(REG_TX_COUNT, '0);                     // zero count, no request
    bus_write(REG_DATA, 32'hFFFF_FF5A);
    bus_write(REG_RX_ADDR, 32'hFFFF_FFFF);
    bus_write(REG_RX_COUNT, 32'd2);                  // empty FIFO: DMA pending
    rx_byte(8'hFF);                                  // straight to memory, addr wraps
    rx_byte(8'h00);
    bus_write(REG_INT_ENABLE, 32'h0000_0001);        // FIFO-not-empty interrupt
    for (int k = 0; k <= FIFO_DEPTH_DEF; k++)        // fill, then one overrun
      rx_byte(k[7:0] ^ 8'hA5);
    bus_read(REG_FIFO_COUNT);
    bus_read(REG_DATA);
    bus_write(REG_RX_COUNT, ALL_ONES);               // drains the rest, stays pending
    bus_read(REG_RX_COUNT);
    bus_write(REG_RX_ADDR, 32'h0000_1000);           // cancels the pending DMA
    bus_write(REG_RX_COUNT, '0);                     // empty FIFO, nothing pending
    bus_write(REG_INT_ENABLE, 32'h0000_0002);

    // ---- random part: register traffic and bursts of received bytes ----
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        rx_byte(8'($urandom_range(0, 255)));
        sent++;
      end else if (sel < 30) begin
        // burst long enough to fill or overrun the FIFO at times
        burst = $urandom_range(4, FIFO_DEPTH_DEF + 3);
        repeat (burst) rx_byte(8'($urandom_range(0, 255)));
        sent += burst;
      end else if (sel < 42) begin
        bus_read(REG_DATA);
        sent++;
      end else if (sel < 54) begin
        bus_read(10'($urandom_range(0, 8)));
        sent++;
      end else if (sel < 58) begin
        bus_read(10'($urandom_range(9, 1023)));
        sent++;
      end else if (sel < 64) begin
        bus_write(REG_INT_ENABLE, ($urandom_range(0, 1) == 0) ? $urandom() :
                  32'($urandom_range(0, 7)));
        sent++;
      end else if (sel < 68) begin
        bus_write(REG_TX_ADDR, $urandom());
        sent++;
      end else if (sel < 74) begin
        bus_write(REG_TX_COUNT, ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom());
        sent++;
      end else if (sel < 79) begin
        bus_write(REG_RX_ADDR, $urandom());
        sent++;
      end else if (sel < 88) begin
        bus_write(REG_RX_COUNT, ($urandom_range(0, 5) == 0) ? $urandom() :
                  32'($urandom_range(0, FIFO_DEPTH_DEF + 4)));
        sent++;
      end else if (sel < 92) begin
        bus_write(REG_DATA, $urandom());
        sent++;
      end else if (sel < 96) begin
        case ($urandom_range(0, 3))
          0:       bus_write(REG_ID, $urandom());
          1:       bus_write(REG_FIFO_COUNT, $urandom());
          2:       bus_write(REG_FIFO_SIZE, $urandom());
          default: bus_write(10'($urandom_range(9, 1023)), $urandom());
        endcase
        sent++;
      end else begin
        send_item(REQ_UNUSED, 12'($urandom_range(0, 4095)), $urandom(),
                  8'($urandom_range(0, 255)));
        sent++;
      end
    end
    push <= 1'b0;

    // ---- wind down ----
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), '0);

    if (sb.errors == 0) begin
      $display("serial_port_rx_fifo_dma: match");
    end else begin
      $display("serial_port_rx_fifo_dma: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("serial_port_rx_fifo_dma: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/spfd_pkg.sv
hw/rtl/spfd_queue.sv
hw/rtl/spfd_front.sv
hw/rtl/spfd_back.sv
hw/rtl/serial_port_rx_fifo_dma.sv
tb/sv/tb_top.sv
